@@ src/ppab_pkg.sv @@
// shared definitions for the premultiplied pixel alpha blend
// format codes, lane masks and the channel types used by the divider pipeline
package ppab_pkg;

    // pixel format codes held in the format register
    localparam logic [2:0] FMT_RGBA   = 3'd0;
    localparam logic [2:0] FMT_RGB32  = 3'd1;
    localparam logic [2:0] FMT_AYUV   = 3'd2;
    localparam logic [2:0] FMT_RGB24  = 3'd3;
    localparam logic [2:0] FMT_RGB565 = 3'd4;
    localparam logic [2:0] FMT_RGB555 = 3'd5;

    // packed lane masks
    localparam logic [31:0] MASK_RB    = 32'h00ff00ff;
    localparam logic [31:0] MASK_G     = 32'h0000ff00;
    localparam logic [15:0] MASK565_RB = 16'hf81f;
    localparam logic [15:0] MASK565_G  = 16'h07e0;
    localparam logic [15:0] MASK555_RB = 16'h7c1f;
    localparam logic [15:0] MASK555_G  = 16'h03e0;

    // colour channels and divider shape
    localparam int CHAN_W          = 8;
    localparam int NUM_CH          = 3;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = CHAN_W / STEPS_PER_STAGE;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0] chan_vec_t;

endpackage

@@ src/premultiplied_pixel_alpha_blend.sv @@
// top level of the premultiplied pixel alpha blend
// blend datapath and format register; depends on ppab_pkg and ppab_unpremul
//
// Usage
//   A pixel pair (src_pixel, dst_pixel) is transferred at a rising edge with
//   start high and busy low. busy is always low: the pipeline takes a new
//   pixel in every cycle, so one pixel per clock is sustained.
//   The result (new_pixel, written) appears on its ports for one cycle with
//   done high, once the pixel has passed the input register and the divider
//   stages. The depth is set by the unpremultiply divider: eight quotient bits,
//   two per stage over four stages, after the input register. Blend modes use
//   one multiply stage and one add stage and travel alongside to keep a fixed
//   latency. The receiver cannot stall, so results are never held; nothing is
//   lost or repeated because the pipeline never stops. pixel_format must be
//   written with cfg_we/cfg_data only while the pipeline is empty; the block
//   does not enforce this. Each pixel carries the format it was accepted with.
//   Reset clears all valid bits, drops done and sets the format to rgb32.
module premultiplied_pixel_alpha_blend (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] src_pixel,
    input  logic [31:0] dst_pixel,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_data,
    output logic        done,
    output logic [31:0] new_pixel,
    output logic        written
);
    import ppab_pkg::*;

    // format register
    logic [2:0] fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_RGB32;
        else if (cfg_we)
            fmt_reg <= cfg_data;
    end

    assign busy = 1'b0;

    // valid bits
    logic valid1_reg, valid2_reg, valid3_reg, valid4_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid1_reg <= start && !busy;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
            done_reg   <= valid4_reg;
        end
    end

    // stage 1: input register
    logic [31:0] s1_reg, d1_reg;
    logic [2:0]  fmt1_reg;

    always_ff @(posedge clk)
    begin
        s1_reg   <= src_pixel;
        d1_reg   <= dst_pixel;
        fmt1_reg <= fmt_reg;
    end

    // unpremultiply divider, four stages from stage 1
    chan_vec_t div_color;
    chan_vec_t div_quot;

    assign div_color = {s1_reg[23:16], s1_reg[15:8], s1_reg[7:0]};

    ppab_unpremul u_unpremul (
        .clk   (clk),
        .alpha (s1_reg[31:24]),
        .color (div_color),
        .quot  (div_quot)
    );

    // stage 2: byte products and 16-bit lane products
    logic [15:0] pb_next, pg_next, pr_next;
    logic [15:0] m_rb_next, m_g_next;
    logic [20:0] mrb_next, mg_next;

    always_comb
    begin
        pb_next = 16'(d1_reg[7:0])   * 16'(s1_reg[31:24]);
        pg_next = 16'(d1_reg[15:8])  * 16'(s1_reg[31:24]);
        pr_next = 16'(d1_reg[23:16]) * 16'(s1_reg[31:24]);
        if (fmt1_reg == FMT_RGB555)
        begin
            m_rb_next = MASK555_RB;
            m_g_next  = MASK555_G;
        end
        else
        begin
            m_rb_next = MASK565_RB;
            m_g_next  = MASK565_G;
        end
        mrb_next = 21'(d1_reg[15:0] & m_rb_next) * 21'(s1_reg[31:27]);
        mg_next  = 21'(d1_reg[15:0] & m_g_next)  * 21'(s1_reg[31:27]);
    end

    logic [31:0] s2_reg, d2_reg;
    logic [2:0]  fmt2_reg;
    logic [15:0] pb2_reg, pg2_reg, pr2_reg;
    logic [15:0] m_rb2_reg, m_g2_reg;
    logic [20:0] mrb2_reg, mg2_reg;

    always_ff @(posedge clk)
    begin
        s2_reg    <= s1_reg;
        d2_reg    <= d1_reg;
        fmt2_reg  <= fmt1_reg;
        pb2_reg   <= pb_next;
        pg2_reg   <= pg_next;
        pr2_reg   <= pr_next;
        m_rb2_reg <= m_rb_next;
        m_g2_reg  <= m_g_next;
        mrb2_reg  <= mrb_next;
        mg2_reg   <= mg_next;
    end

    // stage 3: lane sums and mode select
    logic [31:0] tbr, tg, rgb32_res;
    logic [15:0] p16, lo16;
    logic [31:0] res_next;
    logic        wr_next;
    logic        a_full, a5_full;

    always_comb
    begin
        a_full  = (s2_reg[31:24] == 8'hff);
        a5_full = (s2_reg[31:27] == 5'h1f);

        // packed 8-bit lanes for rgb32 and ayuv
        tbr = {8'h00, pr2_reg, 8'h00} + {24'h000000, pb2_reg[15:8]} + (s2_reg & MASK_RB);
        tg  = {16'h0000, pg2_reg} + (s2_reg & MASK_G);
        rgb32_res = (tbr & MASK_RB) | (tg & MASK_G);

        // source packed to 16 bits, then 5-bit alpha blend
        if (fmt2_reg == FMT_RGB555)
            p16 = {1'b0, s2_reg[23:19], s2_reg[15:11], s2_reg[7:3]};
        else
            p16 = {s2_reg[23:19], s2_reg[15:10], s2_reg[7:3]};
        lo16 = ((16'(mrb2_reg >> 5) + (p16 & m_rb2_reg)) & m_rb2_reg)
             | ((16'(mg2_reg >> 5)  + (p16 & m_g2_reg))  & m_g2_reg);

        res_next = d2_reg;
        wr_next  = 1'b0;
        case (fmt2_reg)
            FMT_RGBA:
            begin
                wr_next = !a_full;
            end
            FMT_RGB32:
            begin
                wr_next = !a_full;
                if (!a_full)
                    res_next = rgb32_res;
            end
            FMT_AYUV:
            begin
                wr_next = !a_full;
                if (!a_full)
                    res_next = {d2_reg[31:24], rgb32_res[23:0]};
            end
            FMT_RGB24:
            begin
                wr_next = !a_full;
                if (!a_full)
                    res_next = {d2_reg[31:24],
                                8'(pr2_reg[15:8] + s2_reg[23:16]),
                                8'(pg2_reg[15:8] + s2_reg[15:8]),
                                8'(pb2_reg[15:8] + s2_reg[7:0])};
            end
            FMT_RGB565, FMT_RGB555:
            begin
                wr_next = !a5_full;
                if (!a5_full)
                    res_next = {d2_reg[31:16], lo16};
            end
            default:
            begin
                wr_next = 1'b0;
            end
        endcase
    end

    logic [31:0] res3_reg;
    logic        wr3_reg;
    logic        rgba3_reg;
    logic [7:0]  atop3_reg;

    always_ff @(posedge clk)
    begin
        res3_reg  <= res_next;
        wr3_reg   <= wr_next;
        rgba3_reg <= (fmt2_reg == FMT_RGBA);
        atop3_reg <= ~s2_reg[31:24];
    end

    // stage 4: wait for the divider
    logic [31:0] res4_reg;
    logic        wr4_reg;
    logic        rgba4_reg;
    logic [7:0]  atop4_reg;

    always_ff @(posedge clk)
    begin
        res4_reg  <= res3_reg;
        wr4_reg   <= wr3_reg;
        rgba4_reg <= rgba3_reg;
        atop4_reg <= atop3_reg;
    end

    // stage 5: blend result lines up with the last divider stage
    logic [31:0] res5_reg;
    logic        wr5_reg;
    logic        rgba5_reg;
    logic [7:0]  atop5_reg;

    always_ff @(posedge clk)
    begin
        res5_reg  <= res4_reg;
        wr5_reg   <= wr4_reg;
        rgba5_reg <= rgba4_reg;
        atop5_reg <= atop4_reg;
    end

    // output: merge the unpremultiplied pixel
    logic [31:0] merged_pixel;
    logic        written_reg;

    always_comb
    begin
        if (rgba5_reg && wr5_reg)
            merged_pixel = {atop5_reg, div_quot[2], div_quot[1], div_quot[0]};
        else
            merged_pixel = res5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            written_reg <= 1'b0;
        else
            written_reg <= valid4_reg && wr4_reg;
    end

    assign done      = done_reg;
    assign new_pixel = merged_pixel;
    assign written   = written_reg;

    // a result only follows a matching earlier transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
    else $error("result without a matching transfer");

    // an unwritten pixel passes the destination through unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !written) |-> (new_pixel == $past(dst_pixel, 5)))
    else $error("unwritten pixel differs from destination");

    // written never appears without its strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        written |-> done && $past(valid4_reg && wr4_reg))
    else $error("written flag outside a result");

endmodule

@@ src/ppab_unpremul.sv @@
// pipelined restoring divider that un-premultiplies three colour channels
// computes min(255, c*256/(256-a)) per channel; depends on ppab_pkg
module ppab_unpremul (
    input  logic                clk,
    input  ppab_pkg::chan_t     alpha,
    input  ppab_pkg::chan_vec_t color,
    output ppab_pkg::chan_vec_t quot
);
    import ppab_pkg::*;

    // per-stage partial remainder, quotient bits, divisor and saturation flags
    chan_vec_t           rem_reg [DIV_STAGES];
    chan_vec_t           q_reg   [DIV_STAGES];
    logic [CHAN_W:0]     bd_reg  [DIV_STAGES];
    logic [NUM_CH-1:0]   sat_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        chan_vec_t         rem_in;
        chan_vec_t         q_in;
        logic [CHAN_W:0]   bd_in;
        logic [NUM_CH-1:0] sat_in;
        chan_vec_t         rem_next;
        chan_vec_t         q_next;

        if (g == 0) begin : g_first
            // divisor is 256 minus alpha; a channel at or above it saturates
            assign rem_in = color;
            assign q_in   = '0;
            assign bd_in  = (CHAN_W+1)'(1 << CHAN_W) - {1'b0, alpha};
            always_comb
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    sat_in[ch] = ({1'b0, color[ch]} >= bd_in);
                end
            end
        end
        else begin : g_later
            assign rem_in = rem_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign bd_in  = bd_reg[g-1];
            assign sat_in = sat_reg[g-1];
        end

        // shift-compare-subtract steps for this stage
        always_comb
        begin
            logic [CHAN_W:0] shifted;
            rem_next = rem_in;
            q_next   = q_in;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                for (int st = 0; st < STEPS_PER_STAGE; st++)
                begin
                    shifted = {rem_next[ch], 1'b0};
                    if (shifted >= bd_in)
                    begin
                        rem_next[ch] = CHAN_W'(shifted - bd_in);
                        q_next[ch]   = {q_next[ch][CHAN_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[ch] = shifted[CHAN_W-1:0];
                        q_next[ch]   = {q_next[ch][CHAN_W-2:0], 1'b0};
                    end
                end
            end
        end

        // stage register
        always_ff @(posedge clk)
        begin
            rem_reg[g] <= rem_next;
            q_reg[g]   <= q_next;
            bd_reg[g]  <= bd_in;
            sat_reg[g] <= sat_in;
        end
    end

    // saturate channels whose quotient would not fit a byte
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            quot[ch] = sat_reg[DIV_STAGES-1][ch] ? {CHAN_W{1'b1}}
                                                 : q_reg[DIV_STAGES-1][ch];
        end
    end

endmodule
